FILE: rtl/segmented_sum_normalizer_top_assert.svh
// Assertion macros shared by the normalizer modules.
`ifndef SEGMENTED_SUM_NORMALIZER_TOP_ASSERT_SVH
`define SEGMENTED_SUM_NORMALIZER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SSN_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define SSN_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SSN_ASSERT_IMPL(label, a, c)
`define SSN_ASSERT_NEXT(label, a, c)
`endif
`endif

FILE: rtl/ssn_pkg.sv
`default_nettype none
package ssn_pkg;
  localparam int MaxLen = 64;
  localparam int IdxW = $clog2(MaxLen);
  localparam int CntW = $clog2(MaxLen + 1);
  localparam int ValW = 24;
  localparam int SumW = 31;
  localparam int QW = 32;
  localparam int NumW = ValW + 16;

  // Job handed from the front part to the back part: one closed run.
  typedef struct packed {
    logic [CntW-1:0] count;
    logic signed [SumW-1:0] sum;
    logic normalize;
    logic vec_end;
  } job_t;
endpackage
`default_nettype wire

FILE: rtl/ssn_front.sv
`default_nettype none
module ssn_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic piecewise_mode,
  input  wire logic push,
  output logic full,
  input  wire logic signed [23:0] value,
  input  wire logic ends_segment,
  input  wire logic ends_vector,
  output logic job_valid,
  output ssn_pkg::job_t job,
  input  wire logic job_ready,
  output logic wr_en,
  output logic [ssn_pkg::IdxW-1:0] wr_addr,
  output logic signed [ssn_pkg::ValW-1:0] wr_data
);
  import ssn_pkg::*;
  `include "segmented_sum_normalizer_top_assert.svh"

  logic [CntW-1:0] held_count;
  logic signed [SumW-1:0] segment_sum;
  logic [CntW-1:0] count_next;
  logic signed [SumW-1:0] sum_next;
  logic room, close_norm, close_raw, acc;

  // The element store is reused, so a new word waits until the back part is idle.
  assign full = job_valid || !job_ready;
  assign acc = push && !full;
  assign room = held_count < CntW'(MaxLen);
  assign wr_en = acc && room;
  assign wr_addr = held_count[IdxW-1:0];
  assign wr_data = value;

  // Classify the closing flags by mode.
  always_comb begin
    close_norm = piecewise_mode ? ends_segment : ends_vector;
    close_raw = piecewise_mode && ends_vector && !ends_segment;
    count_next = room ? held_count + 1'b1 : held_count;
    sum_next = room ? segment_sum + SumW'(value) : segment_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      segment_sum <= '0;
      job_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) job_valid <= 1'b0;
      if (acc) begin
        if (close_norm || close_raw) begin
          job_valid <= 1'b1;
          job.count <= count_next;
          job.sum <= sum_next;
          job.normalize <= close_norm;
          job.vec_end <= ends_vector;
          held_count <= '0;
          segment_sum <= '0;
        end else begin
          held_count <= count_next;
          segment_sum <= sum_next;
        end
      end
    end
  end

  `SSN_ASSERT_IMPL(a_cnt_max, 1'b1, held_count <= CntW'(MaxLen))
  `SSN_ASSERT_NEXT(a_job_clears, acc && (close_norm || close_raw), held_count == '0)
  `SSN_ASSERT_IMPL(a_no_write_busy, job_valid, !wr_en)
endmodule
`default_nettype wire

FILE: rtl/ssn_back.sv
`default_nettype none
module ssn_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire ssn_pkg::job_t job,
  output logic job_ready,
  input  wire logic wr_en,
  input  wire logic [ssn_pkg::IdxW-1:0] wr_addr,
  input  wire logic signed [ssn_pkg::ValW-1:0] wr_data,
  output logic empty,
  input  wire logic pop,
  output logic signed [31:0] ratio,
  output logic last_of_run,
  output logic last_of_vector
);
  import ssn_pkg::*;
  `include "segmented_sum_normalizer_top_assert.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic signed [ValW-1:0] mem [MaxLen];
  logic signed [ValW-1:0] rd_data;
  logic [1:0] state;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] idx_next;
  logic [CntW-1:0] count;
  logic signed [SumW-1:0] sum;
  logic normalize, vec_end, neg;
  logic [NumW-1:0] rem;
  logic [NumW-1:0] quo;
  logic [SumW-1:0] div;
  logic [5:0] step;
  logic [NumW:0] trial;
  logic [NumW-1:0] shifted;
  logic signed [NumW:0] sq;
  logic signed [NumW-1:0] raw;
  logic signed [31:0] res;
  logic lr;

  assign job_ready = (state == S_IDLE);

  // Index of the element to be read next, so the store output lines up with idx.
  always_comb begin
    idx_next = idx;
    if (state == S_IDLE && job_valid) idx_next = '0;
    else if (state == S_OUT && !empty && pop) idx_next = idx + 1'b1;
  end

  // Element store.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[idx_next[IdxW-1:0]];
  end

  // One quotient bit per cycle, restoring division.
  always_comb begin
    shifted = {rem[NumW-2:0], quo[NumW-1]};
    trial = {1'b0, shifted} - {{(NumW - SumW + 1){1'b0}}, div};
    sq = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    raw = {rd_data, 16'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      empty <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            count <= job.count;
            sum <= job.sum;
            normalize <= job.normalize && job.sum != '0;
            vec_end <= job.vec_end;
            idx <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          // rd_data for idx is valid in this cycle.
          lr <= (idx + 1'b1 == count);
          if (normalize) begin
            neg <= rd_data[ValW-1] ^ sum[SumW-1];
            quo <= rd_data[ValW-1] ? NumW'(-raw) : NumW'(raw);
            rem <= '0;
            div <= sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
            step <= '0;
            state <= S_DIV;
          end else begin
            // A raw word is scaled by 65536 and saturated to 32 bits.
            if (raw > $signed(NumW'(32'sh7fffffff))) res <= 32'sh7fffffff;
            else if (raw < -$signed(NumW'(33'sh080000000))) res <= 32'sh80000000;
            else res <= QW'(raw);
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (!trial[NumW]) begin
            rem <= trial[NumW-1:0];
            quo <= {quo[NumW-2:0], 1'b1};
          end else begin
            rem <= shifted;
            quo <= {quo[NumW-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == 6'(NumW)) begin
            if (sq > $signed((NumW+1)'(32'sh7fffffff))) res <= 32'sh7fffffff;
            else if (sq < -$signed((NumW+1)'(33'sh080000000))) res <= 32'sh80000000;
            else res <= QW'(sq);
            state <= S_OUT;
          end
        end
        default: begin
          if (empty) begin
            ratio <= res;
            last_of_run <= lr;
            last_of_vector <= lr && vec_end;
            empty <= 1'b0;
          end else if (pop) begin
            empty <= 1'b1;
            idx <= idx + 1'b1;
            state <= lr ? S_IDLE : S_READ;
          end
        end
      endcase
    end
  end

  `SSN_ASSERT_IMPL(a_out_state, !empty, state == S_OUT)
  `SSN_ASSERT_IMPL(a_idx_range, state != S_IDLE, idx < count)
  `SSN_ASSERT_NEXT(a_pop_clears, !empty && pop, empty)
endmodule
`default_nettype wire

FILE: rtl/segmented_sum_normalizer_top.sv
`default_nettype none
// Streaming sum normalizer. Words are buffered and summed; when a run closes,
// each word leaves as word/sum in signed 16.16, saturated (raw word*65536 for
// a zero sum, or a piecewise run open at vector end). Words are taken one per
// cycle while the back part is idle; a closing word makes full rise until its
// run is drained. The bit-serial divider yields one quotient bit per cycle.
module segmented_sum_normalizer_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic cfg_data,
  input  wire logic push,
  output logic full,
  input  wire logic signed [23:0] value,
  input  wire logic ends_segment,
  input  wire logic ends_vector,
  output logic empty,
  input  wire logic pop,
  output logic signed [31:0] ratio,
  output logic last_of_run,
  output logic last_of_vector
);
  import ssn_pkg::*;

  logic piecewise_mode;
  logic job_valid, job_ready, wr_en;
  job_t job;
  logic [IdxW-1:0] wr_addr;
  logic signed [ValW-1:0] wr_data;

  // Mode register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) piecewise_mode <= 1'b0;
    else if (cfg_valid) piecewise_mode <= cfg_data;
  end

  ssn_front u_front (
    .clk, .rst, .piecewise_mode, .push, .full, .value, .ends_segment, .ends_vector,
    .job_valid, .job, .job_ready, .wr_en, .wr_addr, .wr_data
  );

  ssn_back u_back (
    .clk, .rst, .job_valid, .job, .job_ready, .wr_en, .wr_addr, .wr_data,
    .empty, .pop, .ratio, .last_of_run, .last_of_vector
  );
endmodule
`default_nettype wire

FILE: tb/segmented_sum_normalizer_checker.sv
`timescale 1ns / 100ps
module segmented_sum_normalizer_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic cfg_data,
  input  logic push,
  input  logic full,
  input  logic signed [23:0] value,
  input  logic ends_segment,
  input  logic ends_vector,
  input  logic empty,
  input  logic pop,
  input  logic signed [31:0] ratio,
  input  logic last_of_run,
  input  logic last_of_vector,
  output int   fail_count,
  output int   pending
);
  import ssn_pkg::*;

  typedef struct packed {
    logic signed [31:0] ratio;
    logic run_end;
    logic vec_end;
  } norm_word_t;

  norm_word_t expected_words[$];
  logic signed [23:0] held_elems [MaxLen];
  logic signed [SumW-1:0] run_sum;
  int held_n;
  logic mode_piecewise;

  assign pending = expected_words.size();

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Quotient of elem*65536 by the run sum, truncated toward zero.
  function automatic logic signed [31:0] q16_ratio(input logic signed [23:0] e,
                                                   input logic signed [SumW-1:0] s);
    longint num;
    longint den;
    num = longint'(e) * 65536;
    den = longint'(s);
    return clip32(num / den);
  endfunction

  // Predict the words produced by one accepted element.
  task automatic predict_words(input logic signed [23:0] v, input logic seg,
                               input logic vec);
    logic norm;
    logic raw;
    norm_word_t w;
    if (held_n < MaxLen) begin
      held_elems[held_n] = v;
      run_sum = run_sum + SumW'(v);
      held_n++;
    end
    norm = mode_piecewise ? seg : vec;
    raw = mode_piecewise && vec && !seg;
    if (norm || raw) begin
      for (int k = 0; k < held_n; k++) begin
        if (norm && run_sum != 0) w.ratio = q16_ratio(held_elems[k], run_sum);
        else w.ratio = clip32(longint'(held_elems[k]) * 65536);
        w.run_end = (k + 1 == held_n);
        w.vec_end = (k + 1 == held_n) && vec;
        expected_words.push_back(w);
      end
      held_n = 0;
      run_sum = '0;
    end
  endtask

  // Watch all channels at each edge.
  always @(posedge clk) begin
    norm_word_t want;
    if (rst) begin
      held_n = 0;
      run_sum = '0;
      mode_piecewise = 1'b0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) mode_piecewise = cfg_data;
      if (!empty && pop) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word ratio=%0d", $time, ratio);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (want.ratio !== ratio) begin
            $display("%0t: ratio expected %0d actual %0d", $time, want.ratio, ratio);
            fail_count++;
          end
          if (want.run_end !== last_of_run) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time, want.run_end,
                     last_of_run);
            fail_count++;
          end
          if (want.vec_end !== last_of_vector) begin
            $display("%0t: last_of_vector expected %0b actual %0b", $time, want.vec_end,
                     last_of_vector);
            fail_count++;
          end
        end
      end
      if (push && !full) predict_words(value, ends_segment, ends_vector);
    end
  end
endmodule

FILE: tb/segmented_sum_normalizer_top_test.sv
`timescale 1ns / 100ps
module segmented_sum_normalizer_top_test;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic push = 1'b0;
  logic full;
  logic signed [23:0] value = '0;
  logic ends_segment = 1'b0;
  logic ends_vector = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [31:0] ratio;
  logic last_of_run;
  logic last_of_vector;
  int fail_count;
  int pending;
  int cycles = 0;
  bit drain_idle = 1'b0;

  localparam int CycleLimit = 3000000;

  segmented_sum_normalizer_top dut (.*);
  segmented_sum_normalizer_checker watcher (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Give up if the run stalls.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random pop stalls, sometimes none at all.
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      gap = drain_idle ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk iff !empty);
    end
  end

  // Send one word, after a random number of idle cycles unless no_gap is set.
  task automatic send_word(input logic signed [23:0] v, input logic seg,
                           input logic vec, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    value <= v;
    ends_segment <= seg;
    ends_vector <= vec;
    @(posedge clk iff !full);
  endtask

  // Wait for all words to drain, then for the divider to go quiet.
  task automatic drain_all();
    push <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain_all();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [23:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return 24'($urandom_range(0, 40)) - 24'sd20;
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    int len;
    int sent;
    bit burst;
    logic seg;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: whole-vector extremes, zero sum, overflow.
    write_mode(1'b0);
    send_word(24'sh7fffff, 1'b0, 1'b0, 1'b0);
    send_word(24'sh000001, 1'b1, 1'b1, 1'b0);
    send_word(24'sh800000, 1'b0, 1'b0, 1'b0);
    send_word(24'sh7fffff, 1'b0, 1'b0, 1'b0);
    send_word(24'sh000001, 1'b0, 1'b1, 1'b0);
    send_word(24'sh000005, 1'b0, 1'b0, 1'b0);
    send_word(-24'sd5, 1'b0, 1'b1, 1'b0);
    send_word(24'sh000000, 1'b0, 1'b1, 1'b0);
    send_word(24'sh000003, 1'b0, 1'b0, 1'b0);
    send_word(-24'sd1, 1'b0, 1'b1, 1'b0);
    // Piecewise: both flags, segment only, open run left raw at vector end.
    write_mode(1'b1);
    send_word(24'sh000004, 1'b1, 1'b0, 1'b0);
    send_word(24'sh000002, 1'b0, 1'b0, 1'b0);
    send_word(24'sh000006, 1'b1, 1'b1, 1'b0);
    send_word(24'sh7fffff, 1'b0, 1'b0, 1'b0);
    send_word(24'sh800000, 1'b0, 1'b1, 1'b0);
    send_word(24'sh000001, 1'b1, 1'b1, 1'b0);
    // Mode change mid-run: buffered words stay.
    send_word(24'sh000009, 1'b0, 1'b0, 1'b0);
    write_mode(1'b0);
    send_word(24'sh000003, 1'b1, 1'b1, 1'b0);
    // Buffer overflow: 70 words, the extras are dropped.
    for (int i = 0; i < 70; i++) send_word(rand_value(), 1'b0, i == 69, 1'b1);

    // Random vectors, mostly short, in both modes.
    sent = 0;
    while (sent < 360) begin
      if ($urandom_range(0, 9) == 0) write_mode($urandom_range(0, 1));
      if ($urandom_range(0, 40) == 0) len = $urandom_range(60, 68);
      else len = $urandom_range(1, 8);
      burst = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
        seg = ($urandom_range(0, 3) == 0);
        send_word(rand_value(), seg, i == len - 1, burst);
      end
      sent += len;
      if ($urandom_range(0, 30) == 0) drain_all();
    end

    drain_idle = 1'b1;
    drain_all();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
